@@ rtl/astm_frame_receiver_unit_macros.svh @@
// Assertion macros for the frame receiver checker.
// Both expect i_clk and i_rst_n in scope.
`ifndef ASTM_FRAME_RECEIVER_UNIT_MACROS_SVH
`define ASTM_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/afr_pkg.sv @@
package afr_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_ETB = 8'h17;

    localparam logic [2:0] EV_ACCEPT = 3'd0;
    localparam logic [2:0] EV_REJECT = 3'd1;
    localparam logic [2:0] EV_ENQ    = 3'd2;
    localparam logic [2:0] EV_EOT    = 3'd3;
    localparam logic [2:0] EV_ACK    = 3'd4;
    localparam logic [2:0] EV_NAK    = 3'd5;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [1:0] reply_code;
        logic       intermediate_frame;
        logic [7:0] computed_sum;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_emit;

endpackage

@@ rtl/afr_frame_ctrl.sv @@
module afr_frame_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    output afr_pkg::t_emit o_emit
);
    import afr_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_BODY    = 3'd1;
    localparam logic [2:0] PH_CHK_HI  = 3'd2;
    localparam logic [2:0] PH_CHK_LO  = 3'd3;
    localparam logic [2:0] PH_WAIT_CR = 3'd4;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        begin
            case (c) inside
                [8'h30:8'h39]: r = {1'b1, c[3:0]};
                [8'h41:8'h46]: r = {1'b1, 4'(c[3:0] + 4'd9)};
                default:       r = 5'b0;
            endcase
            return r;
        end
    endfunction

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_check, n_check;
    logic             r_hex_ok, n_hex_ok;
    logic             r_etb, n_etb;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;

    logic [4:0] nib;
    logic       ok;

    assign nib = hex_nibble(i_byte);
    // the CR itself counts towards the length bound
    assign ok  = r_hex_ok && !r_ovf && (r_len < LEN_MAX) && (r_check == r_sum);

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_check  = r_check;
        n_hex_ok = r_hex_ok;
        n_etb    = r_etb;
        n_len    = r_len;
        n_ovf    = r_ovf;
        o_emit   = '0;

        // length count for every byte after STX
        if (r_phase != PH_IDLE) begin
            if (r_len >= LEN_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_len = r_len + LEN_ONE;
            end
        end

        unique case (r_phase)
            PH_IDLE: begin
                case (i_byte)
                    CH_ENQ: begin
                        o_emit.valid          = 1'b1;
                        o_emit.res.event_kind = EV_ENQ;
                        o_emit.res.reply_code = REPLY_ACK;
                    end
                    CH_EOT: begin
                        o_emit.valid          = 1'b1;
                        o_emit.res.event_kind = EV_EOT;
                    end
                    CH_ACK: begin
                        o_emit.valid          = 1'b1;
                        o_emit.res.event_kind = EV_ACK;
                    end
                    CH_NAK: begin
                        o_emit.valid          = 1'b1;
                        o_emit.res.event_kind = EV_NAK;
                    end
                    default: ;
                endcase
            end
            PH_BODY: begin
                n_sum = r_sum + i_byte;
                if (i_byte == CH_ETX || i_byte == CH_ETB) begin
                    n_etb   = (i_byte == CH_ETB);
                    n_phase = PH_CHK_HI;
                end
            end
            PH_CHK_HI: begin
                n_check = {nib[3:0], 4'b0};
                if (!nib[4]) n_hex_ok = 1'b0;
                n_phase = PH_CHK_LO;
            end
            PH_CHK_LO: begin
                n_check = {r_check[7:4], nib[3:0]};
                if (!nib[4]) n_hex_ok = 1'b0;
                n_phase = PH_WAIT_CR;
            end
            PH_WAIT_CR: begin
                if (i_byte == CH_CR) begin
                    n_phase                       = PH_IDLE;
                    o_emit.valid                  = 1'b1;
                    o_emit.res.event_kind         = ok ? EV_ACCEPT : EV_REJECT;
                    o_emit.res.reply_code         = ok ? REPLY_ACK : REPLY_NAK;
                    o_emit.res.intermediate_frame = r_etb;
                    o_emit.res.computed_sum       = r_sum;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // STX opens a frame when idle and restarts one inside the body
        if ((r_phase == PH_IDLE || r_phase == PH_BODY) && i_byte == CH_STX) begin
            n_phase  = PH_BODY;
            n_sum    = '0;
            n_check  = '0;
            n_hex_ok = 1'b1;
            n_etb    = 1'b0;
            n_len    = LEN_ONE;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_sum    <= '0;
            r_check  <= '0;
            r_hex_ok <= 1'b1;
            r_etb    <= 1'b0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_check  <= n_check;
            r_hex_ok <= n_hex_ok;
            r_etb    <= n_etb;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
        end
    end

endmodule

@@ rtl/afr_out_stage.sv @@
module afr_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  afr_pkg::t_emit   i_emit,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output afr_pkg::t_result o_res
);
    import afr_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    load;

    assign load    = i_fire && i_emit.valid;
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_emit.res;
        end
    end

endmodule

@@ rtl/astm_frame_receiver_unit.sv @@
// Path: a byte taken on the slave side is held in the input register, decoded
// combinationally, and any event it causes is registered in the output stage.
// Throughput: one byte per cycle, set by the single-pass decode stage; the
// slave side stalls only while the input and output registers are both held.
// Reset: synchronous, active low; returns to idle with both registers empty.
module astm_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [1:0] reply_code, [2] intermediate_frame,
                                          // [10:3] computed_sum, [15:11] zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] event_kind
);
    import afr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       fire;
    logic       out_free;
    t_emit      emit;
    t_result    res;

    assign fire            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    afr_frame_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_emit  (emit)
    );

    afr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_emit  (emit),
        .i_ready (i_m_axis_tready),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {5'b0, res.computed_sum, res.intermediate_frame, res.reply_code};
    assign o_m_axis_tuser = res.event_kind;

endmodule

@@ rtl/afr_checker.sv @@
`include "astm_frame_receiver_unit_macros.svh"

module afr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [2:0]  i_m_tuser
);
    import afr_pkg::*;

    logic is_ctrl_ev;

    assign is_ctrl_ev = (i_m_tuser == EV_ENQ) || (i_m_tuser == EV_EOT) ||
                        (i_m_tuser == EV_ACK) || (i_m_tuser == EV_NAK);

    `AFR_ASSERT_NEXT(a_out_hold, i_m_tvalid && !i_m_tready, i_m_tvalid, "stalled transfer dropped")
    `AFR_ASSERT_NOW(a_accept_ack, i_m_tvalid && i_m_tuser == EV_ACCEPT, i_m_tdata[1:0] == REPLY_ACK, "accepted frame without ACK")
    `AFR_ASSERT_NOW(a_reject_nak, i_m_tvalid && i_m_tuser == EV_REJECT, i_m_tdata[1:0] == REPLY_NAK, "rejected frame without NAK")
    `AFR_ASSERT_NOW(a_ctrl_clean, i_m_tvalid && is_ctrl_ev, i_m_tdata[10:2] == 9'd0, "control event carries frame data")

endmodule

bind astm_frame_receiver_unit afr_checker u_afr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

@@ test/tb_astm_frame_receiver_unit.sv @@
`timescale 1ns / 1ps

module tb_astm_frame_receiver_unit;
    import afr_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_BODY,
        RX_CHK_HI,
        RX_CHK_LO,
        RX_WAIT_CR
    } t_rx_phase;

    typedef enum int {
        CHK_GOOD,
        CHK_WRONG,
        CHK_LOWER,
        CHK_JUNK
    } t_chk_fault;

    localparam logic [7:0] CH_LF = 8'h0A;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;    // [1:0] reply_code, [2] intermediate_frame,
                                    // [10:3] computed_sum, [15:11] zero
    logic [2:0]  o_m_axis_tuser;    // [2:0] event_kind

    astm_frame_receiver_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // receiver state as the link sees it
    t_rx_phase  rx_phase;
    logic [7:0] rx_sum;
    logic [7:0] rx_check;
    logic       rx_hex_ok;
    logic       rx_etb;
    int         rx_len;
    logic       rx_over;

    t_result    pending_events [$];
    int         err_count;
    int         bytes_sent;
    int         src_calm;
    int         snk_calm;
    int         sink_wait;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] decode_hex(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b1, 4'(c - 8'h41 + 10)};
        return 5'd0;
    endfunction

    function automatic void clear_receiver();
        rx_phase  = RX_IDLE;
        rx_sum    = 8'd0;
        rx_check  = 8'd0;
        rx_hex_ok = 1'b1;
        rx_etb    = 1'b0;
        rx_len    = 0;
        rx_over   = 1'b0;
    endfunction

    function automatic void open_frame();
        rx_phase  = RX_BODY;
        rx_sum    = 8'd0;
        rx_check  = 8'd0;
        rx_hex_ok = 1'b1;
        rx_etb    = 1'b0;
        rx_len    = 1;
        rx_over   = 1'b0;
    endfunction

    function automatic void count_frame_byte();
        if (rx_len >= MAX_FRAME_BYTES)
            rx_over = 1'b1;
        else
            rx_len++;
    endfunction

    function automatic void post_event(logic [2:0] kind, logic [1:0] reply,
                                       logic inter, logic [7:0] sum);
        pending_events.push_back(t_result'{event_kind: kind, reply_code: reply,
                                           intermediate_frame: inter,
                                           computed_sum: sum});
    endfunction

    function automatic void track_rx_byte(logic [7:0] b);
        logic [4:0] nib;
        logic       ok;
        case (rx_phase)
            RX_IDLE: begin
                case (b)
                    CH_ENQ: post_event(EV_ENQ, REPLY_ACK, 1'b0, 8'd0);
                    CH_EOT: post_event(EV_EOT, REPLY_NONE, 1'b0, 8'd0);
                    CH_ACK: post_event(EV_ACK, REPLY_NONE, 1'b0, 8'd0);
                    CH_NAK: post_event(EV_NAK, REPLY_NONE, 1'b0, 8'd0);
                    CH_STX: open_frame();
                    default: ;
                endcase
            end
            RX_BODY: begin
                if (b == CH_STX) begin
                    open_frame();
                end else begin
                    count_frame_byte();
                    rx_sum = rx_sum + b;
                    if (b == CH_ETX || b == CH_ETB) begin
                        rx_etb   = (b == CH_ETB);
                        rx_phase = RX_CHK_HI;
                    end
                end
            end
            RX_CHK_HI: begin
                count_frame_byte();
                nib = decode_hex(b);
                if (!nib[4]) rx_hex_ok = 1'b0;
                rx_check = {nib[3:0], 4'd0};
                rx_phase = RX_CHK_LO;
            end
            RX_CHK_LO: begin
                count_frame_byte();
                nib = decode_hex(b);
                if (!nib[4]) rx_hex_ok = 1'b0;
                rx_check = rx_check | {4'd0, nib[3:0]};
                rx_phase = RX_WAIT_CR;
            end
            RX_WAIT_CR: begin
                count_frame_byte();
                if (b == CH_CR) begin
                    ok = rx_hex_ok && !rx_over && rx_check == rx_sum;
                    rx_phase = RX_IDLE;
                    post_event(ok ? EV_ACCEPT : EV_REJECT, ok ? REPLY_ACK : REPLY_NAK,
                               rx_etb, rx_sum);
                end
            end
            default: rx_phase = RX_IDLE;
        endcase
    endfunction

    // one transfer on the slave side; returns just after the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_bytes(input t_byte_q q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    function automatic t_byte_q rand_body(int len);
        t_byte_q    q;
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_STX || b == CH_ETX || b == CH_ETB) b = b ^ 8'h80;
            q.push_back(b);
        end
        return q;
    endfunction

    task automatic send_frame(input t_byte_q body, input logic [7:0] ending,
                              input t_chk_fault fault, input int tail_len);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] junk;
        t_byte_q    q;
        sum = ending;
        foreach (body[i]) sum = sum + body[i];
        hi = hex_digit(sum[7:4]);
        lo = hex_digit(sum[3:0]);
        case (fault)
            CHK_WRONG: lo = hex_digit(sum[3:0] + 4'd1);
            CHK_LOWER: hi = 8'(8'h61 + $urandom_range(0, 5));
            CHK_JUNK: begin
                if ($urandom_range(0, 1)) hi = 8'($urandom_range(0, 255));
                else lo = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        q.push_back(CH_STX);
        q = {q, body};
        q.push_back(ending);
        q.push_back(hi);
        q.push_back(lo);
        for (int i = 0; i < tail_len; i++) begin
            junk = 8'($urandom_range(0, 255));
            q.push_back((junk == CH_CR) ? CH_LF : junk);
        end
        q.push_back(CH_CR);
        send_bytes(q);
    endtask

    task automatic test_idle_controls();
        send_bytes('{CH_ENQ, CH_EOT, CH_ACK, CH_NAK, 8'h00, 8'hFF, CH_LF, CH_CR,
                     CH_ETX, CH_ETB});
    endtask

    task automatic test_frame_endings();
        send_frame('{8'h31, 8'h48}, CH_ETX, CHK_GOOD, 0);
        send_frame('{8'hFC}, CH_ETB, CHK_GOOD, 0);       // sum 13
        send_frame('{8'hFD}, CH_ETX, CHK_GOOD, 0);       // sum 00
        send_frame('{CH_ENQ, CH_EOT, CH_ACK, CH_NAK, CH_CR, 8'h80}, CH_ETB, CHK_GOOD, 0);
        send_byte(CH_LF);
    endtask

    task automatic test_checksum_faults();
        send_frame('{8'h41}, CH_ETX, CHK_WRONG, 0);
        send_frame('{8'h42}, CH_ETX, CHK_LOWER, 0);
        send_frame('{8'h43}, CH_ETB, CHK_JUNK, 0);
        send_frame('{8'h44}, CH_ETX, CHK_GOOD, 3);       // junk before CR
    endtask

    task automatic test_restart();
        send_bytes('{CH_STX, 8'h58, 8'h59});
        send_frame('{8'h5A}, CH_ETX, CHK_GOOD, 0);
    endtask

    task automatic test_length_bound();
        // whole frame incl. STX and CR: 4096 fits, 4097 and beyond overflow
        send_frame(rand_body(MAX_FRAME_BYTES - 5), CH_ETX, CHK_GOOD, 0);
        send_frame(rand_body(MAX_FRAME_BYTES - 4), CH_ETB, CHK_GOOD, 0);
        send_frame(rand_body(MAX_FRAME_BYTES + 100), CH_ETX, CHK_GOOD, 2);
    endtask

    task automatic test_random_traffic();
        int      start;
        int      pick;
        int      len;
        t_byte_q q;
        start = bytes_sent;
        while (bytes_sent - start < 1250) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                                : $urandom_range(0, 24);
            if (pick < 55) begin
                if ($urandom_range(0, 3) == 0) send_byte(CH_ENQ);
                send_frame(rand_body(len), $urandom_range(0, 1) ? CH_ETB : CH_ETX,
                           CHK_GOOD, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
                if ($urandom_range(0, 1)) send_byte(CH_LF);
                if ($urandom_range(0, 5) == 0) send_byte(CH_EOT);
            end else if (pick < 70) begin
                send_frame(rand_body(len), $urandom_range(0, 1) ? CH_ETB : CH_ETX,
                           t_chk_fault'($urandom_range(1, 3)), 0);
            end else if (pick < 82) begin
                case ($urandom_range(0, 3))
                    0: send_byte(CH_ENQ);
                    1: send_byte(CH_EOT);
                    2: send_byte(CH_ACK);
                    default: send_byte(CH_NAK);
                endcase
            end else if (pick < 92) begin
                q.delete();
                for (int i = 0; i < $urandom_range(1, 6); i++)
                    q.push_back(8'($urandom_range(0, 255)));
                send_bytes(q);
            end else begin
                // truncated or restarted frame
                q = rand_body(len);
                q.push_front(CH_STX);
                if ($urandom_range(0, 1)) q.insert($urandom_range(0, q.size()), CH_STX);
                send_bytes(q);
            end
        end
    endtask

    // sink side: a stall is drawn after every result
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            sink_wait--;
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sink_wait = draw_wait(snk_calm);
            got = t_result'{event_kind: o_m_axis_tuser,
                            reply_code: o_m_axis_tdata[1:0],
                            intermediate_frame: o_m_axis_tdata[2],
                            computed_sum: o_m_axis_tdata[10:3]};
            if (pending_events.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transfer kind %0d reply %0d etb %0d sum %02h",
                         $time, got.event_kind, got.reply_code,
                         got.intermediate_frame, got.computed_sum);
            end else begin
                want = pending_events.pop_front();
                if (got !== want || o_m_axis_tdata[15:11] !== 5'd0) begin
                    err_count++;
                    $display("%0t: mismatch exp kind %0d reply %0d etb %0d sum %02h pad 00",
                             $time, want.event_kind, want.reply_code,
                             want.intermediate_frame, want.computed_sum);
                    $display("%0t:          got kind %0d reply %0d etb %0d sum %02h pad %02h",
                             $time, got.event_kind, got.reply_code,
                             got.intermediate_frame, got.computed_sum,
                             o_m_axis_tdata[15:11]);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_astm_frame_receiver_unit: FAIL");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_m_axis_tready = 1'b0;
        err_count       = 0;
        bytes_sent      = 0;
        src_calm        = 0;
        snk_calm        = 0;
        sink_wait       = 0;
        clear_receiver();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_controls();
        test_frame_endings();
        test_checksum_faults();
        test_restart();
        test_length_bound();
        test_random_traffic();

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_astm_frame_receiver_unit: PASS");
        else
            $display("tb_astm_frame_receiver_unit: FAIL");
        $finish;
    end

endmodule
